/* src/fifo_asid_allocator_core_assert.svh */
// ----------------------------------------------------------------------------
// FIFO ASID allocator assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef FIFO_ASID_ALLOCATOR_CORE_ASSERT_SVH
`define FIFO_ASID_ALLOCATOR_CORE_ASSERT_SVH

// Same-cycle implication.
`define FFA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define FFA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/ffa_pkg.sv */
// ----------------------------------------------------------------------------
// ffa_pkg
// Types and constants shared by the FIFO ASID allocator modules.
// ----------------------------------------------------------------------------
package ffa_pkg;

  localparam int SPACE_W     = 8;   // address space id width
  localparam int OWN_W       = 9;   // owner code: 0 free, else space + 1
  localparam int ASID_W      = 8;   // ASID width on the result
  localparam int IN_TDATA_W  = 8;
  localparam int IN_TUSER_W  = 1;
  localparam int OUT_TDATA_W = 24;
  localparam int Q_DEPTH     = 2;   // command queue between front and back

  localparam logic OP_SWITCH  = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  typedef struct packed {
    logic               op;
    logic               in_range;
    logic [SPACE_W-1:0] space;
  } ffa_cmd_t;

  typedef struct packed {
    logic [SPACE_W-1:0] ev_space;
    logic               evicted;
    logic               fresh;
    logic               flush;
    logic [ASID_W-1:0]  asid;
  } ffa_res_t;

endpackage

/* src/ffa_ram.sv */
// ----------------------------------------------------------------------------
// ffa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ffa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/ffa_front.sv */
// ----------------------------------------------------------------------------
// ffa_front
// Accepts input transfers, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
module ffa_front #(
  parameter int NUM_SPACES = 256
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [ffa_pkg::IN_TDATA_W-1:0]      in_tdata,
  input  logic [ffa_pkg::IN_TUSER_W-1:0]      in_tuser,
  output logic                                cmd_valid,
  output ffa_pkg::ffa_cmd_t                   cmd,
  input  logic                                cmd_pop
);

  import ffa_pkg::*;

  localparam int PW = $clog2(Q_DEPTH);

  ffa_cmd_t       q_r [Q_DEPTH];
  logic [PW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [PW:0]    count_r, count_nxt;
  ffa_cmd_t       cls;
  logic           push;

  // Classify: spaces beyond the table are flagged and later ignored.
  always_comb begin
    cls.op       = in_tuser[0];
    cls.space    = in_tdata[SPACE_W-1:0];
    cls.in_range = (int'(in_tdata[SPACE_W-1:0]) < NUM_SPACES);
  end

  assign in_tready = (count_r != (PW+1)'(Q_DEPTH));
  assign push      = in_tvalid && in_tready;
  assign cmd_valid = (count_r != '0);
  assign cmd       = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? PW'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = cmd_pop ? PW'(rd_ptr_r + 1'b1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !cmd_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && cmd_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cls;
    end
  end

endmodule

/* src/ffa_back.sv */
// ----------------------------------------------------------------------------
// ffa_back
// Sequencer that walks the owner and space tables and builds each result.
// ----------------------------------------------------------------------------
`include "fifo_asid_allocator_core_assert.svh"

module ffa_back #(
  parameter int NUM_ASIDS  = 256,
  parameter int NUM_SPACES = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cmd_valid,
  input  ffa_pkg::ffa_cmd_t  cmd,
  output logic               cmd_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output ffa_pkg::ffa_res_t  out_res
);

  import ffa_pkg::*;

  localparam int AW    = $clog2(NUM_ASIDS);
  localparam int SW    = $clog2(NUM_SPACES);
  localparam int CLR_N = (NUM_ASIDS > NUM_SPACES) ? NUM_ASIDS : NUM_SPACES;
  localparam int CW    = $clog2(CLR_N);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_EVAL  = 3'd2;
  localparam logic [2:0] S_PROBE = 3'd3;
  localparam logic [2:0] S_ALLOC = 3'd4;
  localparam logic [2:0] S_EVICT = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  // Pointer step: wraps modulo the ASID count.
  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    ptr_inc = (int'(p) == NUM_ASIDS - 1) ? '0 : AW'(p + 1'b1);
  endfunction

  // ASID 0 is never handed out.
  function automatic logic [AW-1:0] ptr_fix(input logic [AW-1:0] p);
    ptr_fix = (p == '0) ? AW'(1) : p;
  endfunction

  logic [2:0]       state_r, state_nxt;
  logic [CW-1:0]    clr_cnt_r, clr_cnt_nxt;
  ffa_cmd_t         cur_r, cur_nxt;
  ffa_res_t         res_r, res_nxt;
  logic [AW-1:0]    next_free_r, next_free_nxt;
  logic [OWN_W-1:0] current_r, current_nxt;
  logic [AW-1:0]    alloc_n_r, alloc_n_nxt;
  logic             ev_r, ev_nxt;
  logic [OWN_W-1:0] ev_own_r, ev_own_nxt;
  logic             out_valid_r, out_valid_nxt;
  ffa_res_t         out_res_r, out_res_nxt;

  logic             sa_we;
  logic [SW-1:0]    sa_waddr, sa_raddr;
  logic [AW-1:0]    sa_wdata, sa_rdata;
  logic             ot_we;
  logic [AW-1:0]    ot_waddr, ot_raddr;
  logic [OWN_W-1:0] ot_wdata, ot_rdata;

  logic [SW-1:0]    sp_idx;
  logic [OWN_W-1:0] own_self;
  logic [AW-1:0]    p_now;
  logic             out_free;

  assign sp_idx   = SW'(cur_r.space);
  assign own_self = OWN_W'(cur_r.space) + OWN_W'(1);
  assign p_now    = ptr_fix(next_free_r);
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    cur_nxt       = cur_r;
    res_nxt       = res_r;
    next_free_nxt = next_free_r;
    current_nxt   = current_r;
    alloc_n_nxt   = alloc_n_r;
    ev_nxt        = ev_r;
    ev_own_nxt    = ev_own_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_res_nxt   = out_res_r;
    cmd_pop       = 1'b0;
    sa_we         = 1'b0;
    sa_waddr      = sp_idx;
    sa_wdata      = '0;
    sa_raddr      = SW'(cmd.space);
    ot_we         = 1'b0;
    ot_waddr      = alloc_n_r;
    ot_wdata      = '0;
    ot_raddr      = p_now;

    unique case (state_r)
      S_CLEAR: begin
        sa_we    = (int'(clr_cnt_r) < NUM_SPACES);
        sa_waddr = clr_cnt_r[SW-1:0];
        ot_we    = (int'(clr_cnt_r) < NUM_ASIDS);
        ot_waddr = clr_cnt_r[AW-1:0];
        if (clr_cnt_r == CW'(CLR_N - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          clr_cnt_nxt = clr_cnt_r + 1'b1;
        end
      end
      S_IDLE: begin
        if (cmd_valid) begin
          cmd_pop   = 1'b1;
          cur_nxt   = cmd;
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        // Second probe address in case the first slot belongs to the current space.
        ot_raddr  = ptr_fix(ptr_inc(p_now));
        res_nxt   = '0;
        ev_nxt    = 1'b0;
        state_nxt = S_DONE;
        if (!cur_r.in_range) begin
          // Ignored: result stays all zero.
        end else if (cur_r.op == OP_RELEASE) begin
          sa_we    = 1'b1;
          sa_wdata = '0;
          ot_we    = (sa_rdata != '0);
          ot_waddr = sa_rdata;
          ot_wdata = '0;
          if (current_r == own_self) begin
            current_nxt = '0;
          end
        end else if (current_r == own_self) begin
          res_nxt.asid  = ASID_W'(sa_rdata);
          res_nxt.flush = (sa_rdata != '0);
        end else if (sa_rdata != '0) begin
          res_nxt.asid = ASID_W'(sa_rdata);
          current_nxt  = own_self;
        end else begin
          next_free_nxt = ptr_inc(p_now);
          alloc_n_nxt   = p_now;
          if (ot_rdata == '0) begin
            state_nxt = S_ALLOC;
          end else if (ot_rdata == current_r) begin
            state_nxt = S_PROBE;
          end else begin
            ev_nxt     = 1'b1;
            ev_own_nxt = ot_rdata;
            state_nxt  = S_ALLOC;
          end
        end
      end
      S_PROBE: begin
        // The current space owns one slot at most, so this slot is taken as is.
        next_free_nxt = ptr_inc(p_now);
        alloc_n_nxt   = p_now;
        if (ot_rdata != '0) begin
          ev_nxt     = 1'b1;
          ev_own_nxt = ot_rdata;
        end
        state_nxt = S_ALLOC;
      end
      S_ALLOC: begin
        sa_we            = 1'b1;
        sa_wdata         = alloc_n_r;
        ot_we            = 1'b1;
        ot_waddr         = alloc_n_r;
        ot_wdata         = own_self;
        current_nxt      = own_self;
        res_nxt.asid     = ASID_W'(alloc_n_r);
        res_nxt.flush    = 1'b1;
        res_nxt.fresh    = 1'b1;
        res_nxt.evicted  = ev_r;
        res_nxt.ev_space = ev_r ? SPACE_W'(ev_own_r - OWN_W'(1)) : '0;
        state_nxt        = ev_r ? S_EVICT : S_DONE;
      end
      S_EVICT: begin
        sa_we     = 1'b1;
        sa_waddr  = SW'(ev_own_r - OWN_W'(1));
        sa_wdata  = '0;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = res_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      next_free_r <= '0;
      current_r   <= '0;
      out_valid_r <= 1'b0;
      ev_r        <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      next_free_r <= next_free_nxt;
      current_r   <= current_nxt;
      out_valid_r <= out_valid_nxt;
      ev_r        <= ev_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r     <= cur_nxt;
    res_r     <= res_nxt;
    alloc_n_r <= alloc_n_nxt;
    ev_own_r  <= ev_own_nxt;
    out_res_r <= out_res_nxt;
  end

  ffa_ram #(.WIDTH(AW), .DEPTH(NUM_SPACES)) u_space_asid (
    .clk   (clk),
    .we    (sa_we),
    .waddr (sa_waddr),
    .wdata (sa_wdata),
    .raddr (sa_raddr),
    .rdata (sa_rdata)
  );

  ffa_ram #(.WIDTH(OWN_W), .DEPTH(NUM_ASIDS)) u_owner_table (
    .clk   (clk),
    .we    (ot_we),
    .waddr (ot_waddr),
    .wdata (ot_wdata),
    .raddr (ot_raddr),
    .rdata (ot_rdata)
  );

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  `FFA_ASSERT_NOW(a_no_pop_in_clear, state_r == S_CLEAR, !cmd_pop, "command popped during clear")
  `FFA_ASSERT_NOW(a_alloc_nonzero, state_r == S_ALLOC, alloc_n_r != '0, "ASID 0 allocated")
  `FFA_ASSERT_NOW(a_evict_flag, state_r == S_EVICT, ev_r, "eviction write without eviction")
  `FFA_ASSERT_NEXT(a_release_done, (state_r == S_EVAL) && (cur_r.op == OP_RELEASE), state_r == S_DONE, "release did not finish in one step")

endmodule

/* src/fifo_asid_allocator_core.sv */
// ----------------------------------------------------------------------------
// fifo_asid_allocator_core
// FIFO address-space-id allocator with a decoupled command front end.
// ----------------------------------------------------------------------------
// Each input transfer carries an opcode on in_tuser (switch in or release)
// and an address space id on in_tdata; each one yields exactly one result
// transfer. A switch served from the tables runs the back-end states IDLE,
// EVAL and DONE; a fresh allocation adds ALLOC, an eviction ALLOC and
// EVICT, and a pass over the current space's slot before evicting PROBE,
// ALLOC and EVICT. The back-end sequencer reads the owner table and the
// space table through one read port each and writes each through one write
// port. A two-entry command queue lets the input side keep accepting while
// the back end works, and a result register holds the finished transfer
// while the output side stalls. After reset the back end sweeps both
// tables to zero, one entry per cycle, over the larger of NUM_ASIDS and
// NUM_SPACES entries (256 by default); input transfers are queued but not
// processed until the sweep ends.
// ----------------------------------------------------------------------------
module fifo_asid_allocator_core #(
  parameter int NUM_ASIDS  = 256,   // 4 .. 256
  parameter int NUM_SPACES = 256    // 2 .. 256
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [ffa_pkg::IN_TDATA_W-1:0]       in_tdata,   // [7:0] space_id
  input  logic [ffa_pkg::IN_TUSER_W-1:0]       in_tuser,   // [0] opcode
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // [7:0] asid_out, [8] flush_req, [9] newly_assigned, [10] evicted,
  // [18:11] evicted_space, [23:19] zero
  output logic [ffa_pkg::OUT_TDATA_W-1:0]      out_tdata
);

  import ffa_pkg::*;

  logic     cmd_valid;
  logic     cmd_pop;
  ffa_cmd_t cmd;
  ffa_res_t res;

  // Front end: takes transfers, flags out-of-range spaces and queues them.
  ffa_front #(.NUM_SPACES(NUM_SPACES)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  // Back end: table lookups, FIFO allocation, eviction and the result register.
  ffa_back #(.NUM_ASIDS(NUM_ASIDS), .NUM_SPACES(NUM_SPACES)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  // The result struct is laid out with its last field in the low bits.
  assign out_tdata = {(OUT_TDATA_W - $bits(ffa_res_t))'(0), res};

endmodule

/* dv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the FIFO ASID allocator core. Switch and release
// transfers go in on the input stream. An in-bench allocator model predicts
// every result transfer, and each result is compared field by field. A short
// table of directed operations comes first, then random operation sequences.
// Idle cycles and stalls fall on both streams, with one long output hold-off
// and one pause that drains the block.
// ----------------------------------------------------------------------------
module testbench;
  import ffa_pkg::*;

  localparam int NUM_ASIDS       = 256;
  localparam int NUM_SPACES      = 256;
  localparam int N_DIRECTED      = 19;
  localparam int RANDOM_ITEMS    = 1150;
  localparam int QUIET_TAIL      = 150;   // final items run with no idling
  localparam int HOLD_OFF_AT     = 400;
  localparam int HOLD_OFF_CYCLES = 80;
  localparam int DRAIN_AT        = 700;
  localparam int DRAIN_CYCLES    = 12;    // above the back end's worst-case command path
  // The longest quiet span is the table sweep after reset, and after that
  // the output hold-off. This limit covers both many times.
  localparam int STALL_LIMIT     = 2000;

  // One directed operation. When known is set, the expected result is
  // typed into the row. Otherwise the allocator model supplies it.
  typedef struct packed {
    logic               op;
    logic [SPACE_W-1:0] space;
    logic               known;
    logic [ASID_W-1:0]  asid;
    logic               flush;
    logic               fresh;
    logic               evicted;
    logic [SPACE_W-1:0] ev_space;
  } stim_row_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;   // [7:0] space_id
  logic [IN_TUSER_W-1:0]  in_tuser   = '0;   // [0] opcode
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  // [7:0] asid_out, [8] flush_req, [9] newly_assigned, [10] evicted,
  // [18:11] evicted_space, [23:19] zero
  logic [OUT_TDATA_W-1:0] out_tdata;

  // Allocator model state.
  logic [OWN_W-1:0]  owner_of [NUM_ASIDS];        // 0 free, else space + 1
  logic [ASID_W-1:0] asid_of_space [NUM_SPACES];  // 0 means no ASID
  int unsigned       fifo_ptr;
  logic [OWN_W-1:0]  current_owner;               // 0 none, else space + 1

  ffa_res_t pending_grants [$];

  int  items_sent     = 0;
  int  release_count  = 0;
  int  results_seen   = 0;
  int  fresh_count    = 0;
  int  evict_count    = 0;
  int  passover_count = 0;
  int  error_count    = 0;
  bit  idle_on        = 1'b1;
  bit  stall_on       = 1'b1;
  bit  quiet          = 1'b0;
  bit  hold_off_req   = 1'b0;

  // Opening rows start from reset: re-switch of the current space, release
  // of the current space, release of a space that holds no ASID, and a
  // switch to a space that already holds one. The later rows spread the
  // space id over its extremes and alternating bit patterns.
  stim_row_t directed_rows [N_DIRECTED] = '{
    '{OP_SWITCH,  8'd0,   1'b1, 8'd1, 1'b1, 1'b1, 1'b0, 8'd0},
    '{OP_SWITCH,  8'd0,   1'b1, 8'd1, 1'b1, 1'b0, 1'b0, 8'd0},
    '{OP_SWITCH,  8'd255, 1'b1, 8'd2, 1'b1, 1'b1, 1'b0, 8'd0},
    '{OP_RELEASE, 8'd255, 1'b1, 8'd0, 1'b0, 1'b0, 1'b0, 8'd0},
    '{OP_RELEASE, 8'd255, 1'b1, 8'd0, 1'b0, 1'b0, 1'b0, 8'd0},
    '{OP_SWITCH,  8'd255, 1'b1, 8'd3, 1'b1, 1'b1, 1'b0, 8'd0},
    '{OP_SWITCH,  8'd0,   1'b1, 8'd1, 1'b0, 1'b0, 1'b0, 8'd0},
    '{OP_RELEASE, 8'd0,   1'b1, 8'd0, 1'b0, 1'b0, 1'b0, 8'd0},
    '{OP_SWITCH,  8'd0,   1'b0, 8'd0, 1'b0, 1'b0, 1'b0, 8'd0},
    '{OP_SWITCH,  8'd1,   1'b0, 8'd0, 1'b0, 1'b0, 1'b0, 8'd0},
    '{OP_SWITCH,  8'd128, 1'b0, 8'd0, 1'b0, 1'b0, 1'b0, 8'd0},
    '{OP_SWITCH,  8'd127, 1'b0, 8'd0, 1'b0, 1'b0, 1'b0, 8'd0},
    '{OP_RELEASE, 8'd1,   1'b0, 8'd0, 1'b0, 1'b0, 1'b0, 8'd0},
    '{OP_SWITCH,  8'h55,  1'b0, 8'd0, 1'b0, 1'b0, 1'b0, 8'd0},
    '{OP_SWITCH,  8'hAA,  1'b0, 8'd0, 1'b0, 1'b0, 1'b0, 8'd0},
    '{OP_SWITCH,  8'hAA,  1'b0, 8'd0, 1'b0, 1'b0, 1'b0, 8'd0},
    '{OP_RELEASE, 8'hAA,  1'b0, 8'd0, 1'b0, 1'b0, 1'b0, 8'd0},
    '{OP_SWITCH,  8'd255, 1'b0, 8'd0, 1'b0, 1'b0, 1'b0, 8'd0},
    '{OP_SWITCH,  8'd1,   1'b0, 8'd0, 1'b0, 1'b0, 1'b0, 8'd0}
  };

  fifo_asid_allocator_core #(
    .NUM_ASIDS  (NUM_ASIDS),
    .NUM_SPACES (NUM_SPACES)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // The FIFO pointer wraps and never hands out ASID 0.
  function automatic logic [ASID_W-1:0] take_fifo_slot();
    int unsigned slot;
    slot = fifo_ptr % NUM_ASIDS;
    if (slot == 0) slot = 1;
    fifo_ptr = (slot + 1) % NUM_ASIDS;
    return slot[ASID_W-1:0];
  endfunction

  // Applies one operation to the model and returns the result it yields.
  function automatic ffa_res_t asid_outcome(input logic op, input logic [SPACE_W-1:0] sp);
    ffa_res_t          res;
    logic [ASID_W-1:0] held;
    logic [ASID_W-1:0] slot;
    logic [OWN_W-1:0]  self_code;
    logic [OWN_W-1:0]  own;
    logic [OWN_W-1:0]  victim;
    bit                searching;
    int                tries;
    res       = '0;
    self_code = {1'b0, sp} + 1'b1;
    held      = asid_of_space[sp];
    if (op == OP_RELEASE) begin
      if (held != 0 && owner_of[held] == self_code) owner_of[held] = '0;
      asid_of_space[sp] = '0;
      if (current_owner == self_code) current_owner = '0;
    end else if (current_owner == self_code) begin
      res.asid  = held;
      res.flush = (held != 0);
    end else begin
      if (held == 0) begin
        // Probe slots from the FIFO pointer. The current space's slot is
        // passed over. Any other owner loses its ASID.
        slot      = take_fifo_slot();
        searching = 1'b1;
        tries     = 0;
        while (searching && tries < NUM_ASIDS) begin
          own = owner_of[slot];
          if (own == 0) begin
            searching = 1'b0;
          end else if (own == current_owner) begin
            slot = take_fifo_slot();
            passover_count++;
          end else begin
            victim = own - 1'b1;
            asid_of_space[victim[SPACE_W-1:0]] = '0;
            res.evicted  = 1'b1;
            res.ev_space = victim[SPACE_W-1:0];
            evict_count++;
            searching = 1'b0;
          end
          tries++;
        end
        held              = slot;
        asid_of_space[sp] = held;
        owner_of[held]    = self_code;
        res.flush         = 1'b1;
        res.fresh         = 1'b1;
        fresh_count++;
      end
      res.asid      = held;
      current_owner = self_code;
    end
    return res;
  endfunction

  // Offers one operation, waits for its transfer, and queues the expected
  // result. After the transfer it may leave a short idle burst.
  task automatic send_op(input logic op, input logic [SPACE_W-1:0] sp,
                         input bit known, input ffa_res_t typed);
    ffa_res_t predicted;
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= sp;
    do @(posedge clk); while (!in_tready);
    predicted = asid_outcome(op, sp);
    pending_grants.push_back(known ? typed : predicted);
    items_sent++;
    if (op == OP_RELEASE) release_count++;
    if (!quiet && idle_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  // Stimulus: reset, the directed table, then random operation sequences.
  initial begin
    ffa_res_t         typed;
    stim_row_t        row;
    logic [OWN_W-1:0] own;
    int unsigned      slot;
    int               kind;
    int               target;
    int               other;
    int               total;
    bit               hold_off_done;
    bit               drain_done;
    for (int i = 0; i < NUM_ASIDS; i++) owner_of[i] = '0;
    for (int i = 0; i < NUM_SPACES; i++) asid_of_space[i] = '0;
    fifo_ptr      = 0;
    current_owner = '0;
    hold_off_done = 1'b0;
    drain_done    = 1'b0;
    total         = N_DIRECTED + RANDOM_ITEMS;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < N_DIRECTED; i++) begin
      row            = directed_rows[i];
      typed.asid     = row.asid;
      typed.flush    = row.flush;
      typed.fresh    = row.fresh;
      typed.evicted  = row.evicted;
      typed.ev_space = row.ev_space;
      send_op(row.op, row.space, row.known, typed);
    end

    while (items_sent < total) begin
      if (items_sent >= total - QUIET_TAIL) quiet = 1'b1;
      if ($urandom_range(0, 15) == 0) idle_on = !idle_on;

      // Hold the output side off for a long stretch while input keeps flowing.
      if (!hold_off_done && items_sent >= HOLD_OFF_AT) begin
        hold_off_req  = 1'b1;
        hold_off_done = 1'b1;
      end
      // Stop offering until every outstanding result has come back.
      if (!drain_done && items_sent >= DRAIN_AT) begin
        in_tvalid <= 1'b0;
        do @(posedge clk); while (pending_grants.size() != 0);
        drain_done = 1'b1;
      end

      kind = $urandom_range(0, 99);
      if (kind < 40) begin
        send_op(OP_SWITCH, SPACE_W'($urandom_range(0, 255)), 1'b0, '0);
      end else if (kind < 62) begin
        // Release then switch the same space: always forces a fresh ASID.
        other = $urandom_range(0, 255);
        send_op(OP_RELEASE, SPACE_W'(other), 1'b0, '0);
        send_op(OP_SWITCH, SPACE_W'(other), 1'b0, '0);
      end else if (kind < 77) begin
        // Hot spaces switched twice so the second hits the current space.
        other = $urandom_range(0, 15);
        send_op(OP_SWITCH, SPACE_W'(other), 1'b0, '0);
        send_op(OP_SWITCH, SPACE_W'(other), 1'b0, '0);
      end else if (kind < 87) begin
        send_op(OP_RELEASE, SPACE_W'($urandom_range(0, 255)), 1'b0, '0);
      end else begin
        // Make the owner of the slot under the FIFO pointer current. Then
        // allocate for another space, so the probe has to pass that slot over.
        slot = (fifo_ptr == 0) ? 1 : fifo_ptr;
        own  = owner_of[slot];
        if (own == 0) begin
          send_op(OP_SWITCH, SPACE_W'($urandom_range(0, 255)), 1'b0, '0);
        end else begin
          target = own - 1;
          do other = $urandom_range(0, 255); while (other == target);
          send_op(OP_SWITCH, SPACE_W'(target), 1'b0, '0);
          send_op(OP_RELEASE, SPACE_W'(other), 1'b0, '0);
          send_op(OP_SWITCH, SPACE_W'(other), 1'b0, '0);
        end
      end
    end

    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_grants.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d operations (%0d releases): %0d fresh ASIDs, %0d evictions,",
             items_sent, release_count, fresh_count, evict_count);
    $display("%0d skips of the current slot; checked %0d result transfers, %0d mismatches.",
             passover_count, results_seen, error_count);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Result side: checks each accepted transfer against the oldest expected
  // result, then picks out_tready for the next cycle.
  initial begin
    ffa_res_t got;
    ffa_res_t want;
    int       stall_left;
    stall_left = 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) begin
        results_seen++;
        got = out_tdata[$bits(ffa_res_t)-1:0];
        if (out_tdata[OUT_TDATA_W-1:$bits(ffa_res_t)] != 0) begin
          $error("padding: expected 0, got %0h", out_tdata[OUT_TDATA_W-1:$bits(ffa_res_t)]);
          error_count++;
        end
        if (pending_grants.size() == 0) begin
          $error("result transfer %06h arrived with nothing expected", out_tdata);
          error_count++;
        end else begin
          want = pending_grants.pop_front();
          if (got.asid != want.asid) begin
            $error("asid_out: expected %0d, got %0d", want.asid, got.asid);
            error_count++;
          end
          if (got.flush != want.flush) begin
            $error("flush_req: expected %0d, got %0d", want.flush, got.flush);
            error_count++;
          end
          if (got.fresh != want.fresh) begin
            $error("newly_assigned: expected %0d, got %0d", want.fresh, got.fresh);
            error_count++;
          end
          if (got.evicted != want.evicted) begin
            $error("evicted: expected %0d, got %0d", want.evicted, got.evicted);
            error_count++;
          end
          if (got.ev_space != want.ev_space) begin
            $error("evicted_space: expected %0d, got %0d", want.ev_space, got.ev_space);
            error_count++;
          end
        end
      end

      if ($urandom_range(0, 63) == 0) stall_on = !stall_on;
      if (hold_off_req) begin
        // Long hold-off. The block fills and must stall its input side.
        out_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
        out_tready <= 1'b1;
      end else if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else if (!quiet && stall_on && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        stall_left = $urandom_range(0, 2);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Watchdog: ends the run if neither stream moves for too long.
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("No transfer on either stream for %0d cycles.", STALL_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

endmodule

/* fifo_asid_allocator_core.f */
+incdir+src
src/ffa_pkg.sv
src/ffa_ram.sv
src/ffa_front.sv
src/ffa_back.sv
src/fifo_asid_allocator_core.sv
dv/testbench.sv
